@@ src/tmcw_pkg.sv @@
package tmcw_pkg;

    // field widths of the item channels
    localparam int unsigned OP_W        = 2;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned INDEX_W     = 11;
    localparam int unsigned ROW_OUT_W   = 5;
    localparam int unsigned COL_OUT_W   = 7;
    localparam int unsigned CELL_W      = 16;
    localparam int unsigned COLOR_W     = 4;
    localparam int unsigned CFG_INDEX_W = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'b1;

    // register reset values
    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
    localparam int unsigned       TAB_STEP     = 8;
    localparam int unsigned       TAB_SHIFT    = 3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CHAR_W-1:0]  character;
        logic [INDEX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_column;
        logic [CELL_W-1:0]    read_data;
        logic                 scrolled;
    } t_out_item;

    // what a put-character does besides moving the cursor
    typedef struct packed {
        logic write_cell;
        logic scroll;
    } t_cursor_ctl;

endpackage

@@ src/tmcw_cursor.sv @@
module tmcw_cursor #(
    parameter int COLUMNS    = 80,
    parameter int ROWS_COUNT = 25
) (
    input  logic [$clog2(ROWS_COUNT)-1:0] i_row,
    input  logic [$clog2(COLUMNS)-1:0]    i_col,
    input  logic [tmcw_pkg::CHAR_W-1:0]   i_char,
    output logic [$clog2(ROWS_COUNT)-1:0] o_row,
    output logic [$clog2(COLUMNS)-1:0]    o_col,
    output tmcw_pkg::t_cursor_ctl         o_ctl
);
    import tmcw_pkg::*;

    localparam int RW = $clog2(ROWS_COUNT);
    localparam int CW = $clog2(COLUMNS);

    localparam logic [CW:0]   COL_LIMIT = (CW+1)'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS_COUNT - 1);

    logic [CW:0] col_ext;
    logic [CW:0] col_step;
    logic [CW:0] tab_sum;
    logic        row_inc;
    logic        wrap;
    logic        write_cell;
    logic        scroll;

    assign col_ext = {1'b0, i_col};
    assign tab_sum = col_ext + (CW+1)'(TAB_STEP);

    // column move and control character decode
    always_comb begin
        col_step   = col_ext;
        row_inc    = 1'b0;
        write_cell = 1'b0;
        priority if (i_char == CH_NEWLINE) begin
            col_step = '0;
            row_inc  = 1'b1;
        end else if (i_char == CH_RETURN) begin
            col_step = '0;
        end else if (i_char == CH_BACKSPACE) begin
            if (col_ext != '0) begin
                col_step = col_ext - (CW+1)'(1);
            end
        end else if (i_char == CH_TAB) begin
            col_step = {tab_sum[CW:TAB_SHIFT], TAB_SHIFT'(0)};
        end else begin
            col_step   = col_ext + (CW+1)'(1);
            write_cell = 1'b1;
        end
    end

    // wrap past the last column, scroll past the last row
    assign wrap   = (col_step >= COL_LIMIT);
    assign o_col  = wrap ? '0 : col_step[CW-1:0];
    assign scroll = (row_inc || wrap) && (i_row == LAST_ROW);
    assign o_row  = ((row_inc || wrap) && !scroll) ? i_row + RW'(1) : i_row;
    assign o_ctl  = '{write_cell: write_cell, scroll: scroll};

endmodule

@@ src/text_mode_console_writer.sv @@
// Text-mode console writer. Holds a COLUMNS x ROWS_COUNT screen of 16-bit cells
// (character in the low byte, attribute {background, foreground} in the high byte)
// in a single-port-write, single-port-read memory, plus a cursor. Put-character,
// read and unused operations issue the cell write address (row * COLUMNS +
// column) or the read in the accept cycle, then load the result register,
// which waits while the output is stalled. A put-character that scrolls and a
// clear walk the whole memory with one address counter, one cell per cycle (a
// scroll reads cell i + COLUMNS and writes cell i in the next cycle, blanking
// the last row; a clear writes blanks); cells read before the first clear are
// undefined, and the input is ready only when idle. Color registers are to be
// written on the configuration channel only while idle; the block does not check.
module text_mode_console_writer #(
    parameter int COLUMNS    = 80,
    parameter int ROWS_COUNT = 25
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tmcw_pkg::t_in_item               i_in,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tmcw_pkg::t_out_item              o_out,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tmcw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tmcw_pkg::COLOR_W-1:0]     i_cfg_data
);
    import tmcw_pkg::*;

    localparam int CELL_COUNT = ROWS_COUNT * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(ROWS_COUNT);
    localparam int CW         = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];

    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic               r_scrolled;
    logic               r_rd_ok;
    logic               r_clear_mode;
    logic [AW-1:0]      r_addr;

    // write stage
    logic               r_wr_en;
    logic [AW-1:0]      r_wr_addr;
    logic               r_wr_copy;
    logic               r_wr_blank;
    logic [CHAR_W-1:0]  r_wr_char;
    logic [CELL_W-1:0]  r_rd_data;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_fire;
    logic               out_free;
    logic               walk_copy;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      cur_addr;
    logic [31:0]        index_wide;
    logic               index_ok;
    logic [CELL_W-1:0]  wr_data;
    logic [RW-1:0]      put_row;
    logic [CW-1:0]      put_col;
    t_cursor_ctl        put_ctl;
    logic [31:0]        row_wide;
    logic [31:0]        col_wide;
    logic [CHAR_W-1:0]  attr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // cursor update for a put-character
    tmcw_cursor #(
        .COLUMNS    (COLUMNS),
        .ROWS_COUNT (ROWS_COUNT)
    ) u_cursor (
        .i_row  (r_row),
        .i_col  (r_col),
        .i_char (i_in.character),
        .o_row  (put_row),
        .o_col  (put_col),
        .o_ctl  (put_ctl)
    );

    // color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FOREGROUND_RESET;
            r_bg <= BACKGROUND_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FOREGROUND: r_fg <= i_cfg_data;
                REG_BACKGROUND: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign attr = {r_bg, r_fg};

    // cell address of the cursor and read index check
    assign cur_addr   = AW'(r_row) * ROW_SPAN + AW'(r_col);
    assign index_wide = 32'(i_in.cell_index);
    assign index_ok   = (index_wide < 32'(CELL_COUNT));

    // memory ports
    assign walk_copy = !r_clear_mode && (r_addr < COPY_END);
    assign rd_en     = (in_fire && (i_in.operation == OP_READ) && index_ok)
                    || ((r_state == S_WALK) && walk_copy);
    assign rd_addr   = (r_state == S_WALK) ? r_addr + ROW_SPAN : index_wide[AW-1:0];

    always_comb begin
        priority if (r_wr_blank) begin
            wr_data = {attr, CH_BLANK};
        end else if (r_wr_copy) begin
            wr_data = r_rd_data;
        end else begin
            wr_data = {attr, r_wr_char};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_mem[r_wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if ((i_in.operation == OP_CLEAR)
                        || ((i_in.operation == OP_PUT) && put_ctl.scroll)) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_WALK: begin
                if (r_addr == LAST_CELL) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row        <= '0;
            r_col        <= '0;
            r_wr_en      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scrolled   <= 1'b0;
            r_rd_ok      <= 1'b0;
            r_clear_mode <= 1'b0;
            r_addr       <= '0;
        end else begin
            r_state <= n_state;
            r_wr_en <= 1'b0;

            // new transaction
            if (in_fire) begin
                r_addr       <= '0;
                r_scrolled   <= 1'b0;
                r_rd_ok      <= 1'b0;
                r_clear_mode <= 1'b0;
                unique case (i_in.operation)
                    OP_PUT: begin
                        r_row      <= put_row;
                        r_col      <= put_col;
                        r_scrolled <= put_ctl.scroll;
                        r_wr_en    <= put_ctl.write_cell;
                    end
                    OP_CLEAR: begin
                        r_row        <= '0;
                        r_col        <= '0;
                        r_clear_mode <= 1'b1;
                    end
                    OP_READ: r_rd_ok <= index_ok;
                    OP_NONE: ;
                    default: ;
                endcase
            end

            // walk over the store, one cell per cycle
            if (r_state == S_WALK) begin
                r_wr_en <= 1'b1;
                r_addr  <= r_addr + AW'(1);
            end

            // result register
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // write stage payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_wr_addr  <= cur_addr;
            r_wr_char  <= i_in.character;
            r_wr_copy  <= 1'b0;
            r_wr_blank <= 1'b0;
        end else if (r_state == S_WALK) begin
            r_wr_addr  <= r_addr;
            r_wr_copy  <= walk_copy;
            r_wr_blank <= !walk_copy;
        end
    end

    // result payload
    assign row_wide = 32'(r_row);
    assign col_wide = 32'(r_col);

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out.cursor_row    <= row_wide[ROW_OUT_W-1:0];
            r_out.cursor_column <= col_wide[COL_OUT_W-1:0];
            r_out.read_data     <= r_rd_ok ? r_rd_data : '0;
            r_out.scrolled      <= r_scrolled;
        end
    end

endmodule
